>>> rtl/button_gesture_detector_macros.svh
// Assertion helpers shared by the button gesture detector.
`ifndef BUTTON_GESTURE_DETECTOR_MACROS_SVH
`define BUTTON_GESTURE_DETECTOR_MACROS_SVH

// Checked on every rising edge of clk, skipped while rst is high.
`define BGD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge of clk, including the reset cycles.
`define BGD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/bgd_pkg.sv
package bgd_pkg;

  // One-hot gesture states.
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_ARMED    = 7'b0000010,
    ST_DETECTED = 7'b0000100,
    ST_PRESSED  = 7'b0001000,
    ST_LONG     = 7'b0010000,
    ST_RELEASE  = 7'b0100000,
    ST_CLICK    = 7'b1000000
  } gesture_state_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_DOWN   = 3'd1,
    EV_UP     = 3'd2,
    EV_LONG   = 3'd3,
    EV_DOUBLE = 3'd4
  } event_t;

  localparam int unsigned LimitWidth = 16;

  // Register indexes on the configuration port.
  localparam logic REG_LONG_PUSH    = 1'b0;
  localparam logic REG_DOUBLE_CLICK = 1'b1;

  localparam logic [LimitWidth-1:0] LongPushReset    = 16'd100;
  localparam logic [LimitWidth-1:0] DoubleClickReset = 16'd25;

  typedef struct packed {
    logic [LimitWidth-1:0] long_push_ticks;
    logic [LimitWidth-1:0] double_click_ticks;
  } limits_t;

endpackage

>>> rtl/bgd_fsm.sv
module bgd_fsm
  import bgd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  logic    pin_level,
  input  limits_t limits,
  output event_t  ev
);

  localparam int unsigned CmpWidth = (COUNT_WIDTH > LimitWidth) ? COUNT_WIDTH : LimitWidth;

  gesture_state_t         state, state_next;
  logic [COUNT_WIDTH-1:0] hold_count, hold_count_next;
  logic [COUNT_WIDTH-1:0] gap_count, gap_count_next;
  logic [COUNT_WIDTH-1:0] hold_inc, gap_inc;
  logic                   hold_hit, gap_hit;
  logic                   released;

  assign released = pin_level;
  assign hold_inc = hold_count + 1'b1;
  assign gap_inc  = gap_count + 1'b1;
  assign hold_hit = CmpWidth'(hold_inc) >= CmpWidth'(limits.long_push_ticks);
  assign gap_hit  = CmpWidth'(gap_inc) >= CmpWidth'(limits.double_click_ticks);

  always_comb begin
    state_next      = state;
    hold_count_next = hold_count;
    gap_count_next  = gap_count;
    ev              = EV_NONE;
    case (state)
      ST_ARMED: begin
        state_next = released ? ST_IDLE : ST_DETECTED;
      end
      ST_DETECTED: begin
        if (released) begin
          state_next = ST_ARMED;
        end else begin
          state_next = ST_PRESSED;
          ev         = EV_DOWN;
        end
      end
      ST_PRESSED: begin
        if (released) begin
          state_next      = ST_RELEASE;
          hold_count_next = '0;
        end else if (hold_hit) begin
          state_next      = ST_LONG;
          hold_count_next = '0;
        end else begin
          hold_count_next = hold_inc;
        end
      end
      ST_LONG: begin
        if (released) begin
          state_next = ST_RELEASE;
        end else begin
          state_next = ST_IDLE;
          ev         = EV_LONG;
        end
      end
      ST_RELEASE: begin
        if (released) begin
          state_next = ST_CLICK;
          ev         = EV_UP;
        end else begin
          state_next = ST_PRESSED;
        end
      end
      ST_CLICK: begin
        if (!released) begin
          state_next     = ST_IDLE;
          gap_count_next = '0;
          ev             = EV_DOUBLE;
        end else if (gap_hit) begin
          state_next     = ST_IDLE;
          gap_count_next = '0;
        end else begin
          gap_count_next = gap_inc;
        end
      end
      default: begin
        state_next = released ? ST_IDLE : ST_ARMED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hold_count <= '0;
      gap_count  <= '0;
    end else if (step) begin
      state      <= state_next;
      hold_count <= hold_count_next;
      gap_count  <= gap_count_next;
    end
  end

endmodule

>>> rtl/button_gesture_detector.sv
// Output path: the event of an accepted request is registered into the output
// register, or into the skid register if the consumer stalls, and is shown on
// event_code with out_valid high. Throughput: one request per cycle while events
// are taken; the two-entry output stage (output register plus skid register) keeps in_ready high as a stall begins.
// Reset (rst, synchronous, active high): gesture state idle, both counters zero,
// limits back to 100 and 25 ticks, output stage empty.
module button_gesture_detector
  import bgd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Pin sample channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        pin_level,
  // Event channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_code,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "button_gesture_detector_macros.svh"

  // ---------------------------------------------------------------------------
  // Configuration registers. Each register sits at byte address 4*index, so
  // bit 2 of paddr selects it and the low two bits are ignored. Only the low
  // 16 bits of pwdata are kept.
  // ---------------------------------------------------------------------------
  limits_t limits;
  logic    cfg_write;
  logic    reg_sel;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.long_push_ticks    <= LongPushReset;
      limits.double_click_ticks <= DoubleClickReset;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_LONG_PUSH:    limits.long_push_ticks    <= pwdata[LimitWidth-1:0];
        REG_DOUBLE_CLICK: limits.double_click_ticks <= pwdata[LimitWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LONG_PUSH:    prdata = 32'(limits.long_push_ticks);
      REG_DOUBLE_CLICK: prdata = 32'(limits.double_click_ticks);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Gesture machine. Its state and counters advance only when a request is
  // accepted; the event for that request is formed combinationally and lands
  // in the output stage at the same edge.
  // ---------------------------------------------------------------------------
  logic   in_accept;
  event_t step_event;

  assign in_accept = in_valid && in_ready;

  bgd_fsm #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_fsm (
    .clk      (clk),
    .rst      (rst),
    .step     (in_accept),
    .pin_level(pin_level),
    .limits   (limits),
    .ev       (step_event)
  );

  // ---------------------------------------------------------------------------
  // Output stage. The output register holds the event on offer; the skid
  // register catches one more event while the consumer stalls, so the input
  // side can still take a request in the cycle the stall begins. in_ready
  // drops only once the skid register is full.
  // ---------------------------------------------------------------------------
  event_t out_event, skid_event;
  logic   skid_valid;
  logic   out_take;

  assign out_take   = out_valid && out_ready;
  assign in_ready   = !skid_valid;
  assign event_code = out_event;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // No new request can arrive; drain the skid register when taken.
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (in_accept) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_event <= skid_event;
      end
    end else if (in_accept) begin
      if (!out_valid || out_take) begin
        out_event <= step_event;
      end else begin
        skid_event <= step_event;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  // The skid register fills only behind a full output register.
  `BGD_ASSERT(a_skid_behind_out, skid_valid |-> out_valid, "skid entry without output entry")
  // A request accepted while the consumer stalls must park in the skid register.
  `BGD_ASSERT(a_stall_parks, (in_accept && out_valid && !out_ready) |=> skid_valid, "stalled event lost")
  // Reset empties the output stage.
  `BGD_ASSERT_ALWAYS(a_reset_empty, rst |=> (!out_valid && !skid_valid), "output stage not empty after reset")

endmodule
